// ----- src/fcca_pkg.sv -----
// Shared types and constants for the FAT16-style cluster chain allocator.
// Self-contained; used by fat_cluster_chain_allocator_core.

package fcca_pkg;

    localparam int NUM_CLUSTERS_DEF = 512;

    localparam logic [15:0] LINK_FREE  = 16'h0000;
    localparam logic [15:0] LINK_EOC   = 16'hFFFF;
    localparam logic [15:0] MEDIA_DESC = 16'hFFF8;
    localparam int          FIRST_DATA = 2;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_EXTEND = 2'd1,
        OP_READ   = 2'd2,
        OP_FREE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_EOC  = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_LINK  = 8'b0010_0000,
        S_WALK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } fsm_t;

endpackage

// ----- src/fat_cluster_chain_allocator_core.sv -----
// FAT16-style cluster link table with allocate, extend, read-link and free-chain.
// Depends on fcca_pkg.
//
// The link table sits in one NUM_CLUSTERS x 16 single-port-write, registered-read
// memory; every operation but read-link is a read-modify-write sequence on it, one
// item at a time. After reset the block runs a clearing pass over all NUM_CLUSTERS
// entries (entry 0 = FFF8, entry 1 = FFFF, rest 0) and accepts no word until it
// ends. Allocate scans for the first free entry at one entry per cycle, up to the
// end of the table when it is full; extend then links the given cluster to the new
// one. Free walks the chain at one link per cycle. The memory read port, one access
// per cycle, sets the pace of the scan and the walk. A finished result waits in the
// output register while the next word is accepted.

module fat_cluster_chain_allocator_core #(
    parameter int NUM_CLUSTERS = fcca_pkg::NUM_CLUSTERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] op, [10:2] cluster, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] result_cluster, [17:16] status,
                                   // [26:18] freed_count, rest zero
);
    import fcca_pkg::*;

    localparam int AW = $clog2(NUM_CLUSTERS);
    localparam int CW = $clog2(NUM_CLUSTERS + 1);
    localparam logic [15:0] NC16 = 16'(NUM_CLUSTERS);
    localparam logic [CW-1:0] NC_CNT = CW'(NUM_CLUSTERS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_CLUSTERS - 1);
    localparam logic [CW-1:0] SCAN_START = CW'(FIRST_DATA);

    logic [15:0] mem [NUM_CLUSTERS];
    logic [15:0] rd_data_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    fsm_t          state_reg, state_next;
    op_t           op_reg, op_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [CW-1:0] scan_addr_reg, scan_addr_next;
    logic [AW-1:0] chk_addr_reg, chk_addr_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [15:0]   res_reg, res_next;
    status_t       st_reg, st_next;
    logic [8:0]    freed_reg, freed_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [31:0]   m_tdata_reg, m_tdata_next;

    op_t         in_op;
    logic [8:0]  in_cluster;
    logic [15:0] in_cl16;
    logic        in_ok;
    logic [15:0] nxt;
    logic        nxt_ok;
    logic        out_free;

    assign in_op      = op_t'(s_tdata[1:0]);
    assign in_cluster = s_tdata[10:2];
    assign in_cl16    = 16'(in_cluster);
    assign in_ok      = (in_cl16 >= 16'(FIRST_DATA)) && (in_cl16 < NC16);
    assign nxt        = rd_data_reg;
    assign nxt_ok     = (nxt >= 16'(FIRST_DATA)) && (nxt < NC16);
    assign out_free   = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Table memory; a same-cycle write to the read address is forwarded.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && (mem_waddr == mem_raddr)) begin
            rd_data_reg <= mem_wdata;
        end else begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        cur_next       = cur_reg;
        clr_addr_next  = clr_addr_reg;
        scan_addr_next = scan_addr_reg;
        chk_addr_next  = chk_addr_reg;
        chk_valid_next = chk_valid_reg;
        res_next       = res_reg;
        st_next        = st_reg;
        freed_next     = freed_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = LINK_FREE;
        mem_raddr      = cur_reg;

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == AW'(0)) begin
                    mem_wdata = MEDIA_DESC;
                end else if (clr_addr_reg == AW'(1)) begin
                    mem_wdata = LINK_EOC;
                end
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next        = in_op;
                    cur_next       = AW'(in_cluster);
                    res_next       = 16'h0000;
                    st_next        = ST_OK;
                    freed_next     = 9'd0;
                    scan_addr_next = SCAN_START;
                    chk_valid_next = 1'b0;
                    if (in_op == OP_ALLOC) begin
                        state_next = S_SCAN;
                    end else if (!in_ok) begin
                        st_next    = ST_BAD;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = (op_reg == OP_FREE) ? S_WALK : S_CHK;
            end
            S_CHK: begin
                if (op_reg == OP_READ) begin
                    res_next   = nxt;
                    st_next    = (nxt == LINK_EOC) ? ST_EOC : ST_OK;
                    state_next = S_DONE;
                end else if (nxt == LINK_FREE) begin
                    st_next    = ST_BAD;
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // each read issues in the cycle before the free check of its entry
                if (chk_valid_reg && (nxt == LINK_FREE)) begin
                    mem_we     = 1'b1;
                    mem_waddr  = chk_addr_reg;
                    mem_wdata  = LINK_EOC;
                    res_next   = 16'(chk_addr_reg);
                    st_next    = ST_OK;
                    state_next = (op_reg == OP_EXTEND) ? S_LINK : S_DONE;
                end else if (scan_addr_reg < NC_CNT) begin
                    mem_raddr      = scan_addr_reg[AW-1:0];
                    scan_addr_next = scan_addr_reg + CW'(1);
                    chk_addr_next  = scan_addr_reg[AW-1:0];
                    chk_valid_next = 1'b1;
                end else begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg) begin
                        res_next   = 16'h0000;
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                end
            end
            S_LINK: begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg;
                mem_wdata  = res_reg;
                state_next = S_DONE;
            end
            S_WALK: begin
                if (nxt == LINK_FREE) begin
                    st_next    = ST_BAD;
                    state_next = S_DONE;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = cur_reg;
                    mem_wdata  = LINK_FREE;
                    freed_next = freed_reg + 9'd1;
                    if (nxt == LINK_EOC) begin
                        st_next    = ST_OK;
                        state_next = S_DONE;
                    end else if (!nxt_ok) begin
                        st_next    = ST_BAD;
                        state_next = S_DONE;
                    end else begin
                        cur_next  = nxt[AW-1:0];
                        mem_raddr = nxt[AW-1:0];
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, freed_reg, st_reg, res_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        op_reg        <= op_next;
        cur_reg       <= cur_next;
        scan_addr_reg <= scan_addr_next;
        chk_addr_reg  <= chk_addr_next;
        res_reg       <= res_next;
        st_reg        <= st_next;
        freed_reg     <= freed_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule
